// ===== rtl/rtef_pkg.sv =====
// Shared constants, types and codes of the recent-transmit echo filter.
// No dependencies.
`timescale 1ns / 1ps

package rtef_pkg;

    parameter int RING_ENTRIES = 8;
    parameter int MAX_FRAME    = 2048;

    parameter int SLOT_W = (RING_ENTRIES > 1) ? $clog2(RING_ENTRIES) : 1;
    parameter int ADDR_W = $clog2(MAX_FRAME);
    parameter int LEN_W  = $clog2(MAX_FRAME + 1);
    parameter int POS_W  = $clog2(MAX_FRAME + 2);

    parameter int OQ_DEPTH = 4;
    parameter int OQ_PTR_W = $clog2(OQ_DEPTH);
    parameter int OQ_CNT_W = $clog2(OQ_DEPTH + 2);

    parameter logic OP_TRANSMIT = 1'b0;
    parameter logic OP_RECEIVE  = 1'b1;

    typedef logic [RING_ENTRIES-1:0]      t_mask;
    typedef logic [RING_ENTRIES-1:0][7:0] t_bank_data;

    typedef struct packed {
        logic       valid;
        logic       rx;
        logic       first;
        logic       last;
        logic       cmp_en;
        logic       over;
        t_mask      inlen;
        logic [7:0] data;
    } t_s1_ctl;

endpackage

// ===== rtl/rtef_store.sv =====
// Frame store: one byte-wide bank per ring slot, one write and one read port.
// Depends on rtef_pkg.
`timescale 1ns / 1ps

module rtef_store (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [rtef_pkg::SLOT_W-1:0] i_wslot,
    input  logic [rtef_pkg::ADDR_W-1:0] i_waddr,
    input  logic [7:0]                i_wdata,
    input  logic                      i_re,
    input  logic [rtef_pkg::ADDR_W-1:0] i_raddr,
    output rtef_pkg::t_bank_data      o_rd_data
);
    import rtef_pkg::*;

    for (genvar g = 0; g < RING_ENTRIES; g++) begin : g_bank
        logic [7:0] mem [MAX_FRAME];
        logic [7:0] r_rd;

        always_ff @(posedge i_clk) begin
            if (i_we && (i_wslot == SLOT_W'(g))) begin
                mem[i_waddr] <= i_wdata;
            end
            if (i_re) begin
                r_rd <= mem[i_raddr];
            end
        end

        assign o_rd_data[g] = r_rd;
    end

endmodule

// ===== rtl/rtef_match.sv =====
// Compare stage: checks read-back bytes of all slots, tracks matching slots.
// Depends on rtef_pkg.
`timescale 1ns / 1ps

module rtef_match (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rtef_pkg::t_s1_ctl    i_s1,
    input  rtef_pkg::t_bank_data i_rd_data,
    input  rtef_pkg::t_mask      i_slot_valid,
    input  rtef_pkg::t_mask      i_tx_clr,
    output logic                 o_push,
    output logic                 o_echo,
    output logic                 o_over
);
    import rtef_pkg::*;

    t_mask r_sm;
    t_mask n_sm;
    t_mask base;
    t_mask cur;

    always_comb begin
        base = i_s1.first ? i_slot_valid : r_sm;
        cur  = base;
        for (int s = 0; s < RING_ENTRIES; s++) begin
            if (i_s1.cmp_en && i_s1.inlen[s] && (i_rd_data[s] != i_s1.data)) begin
                cur[s] = 1'b0;
            end
        end
        n_sm   = r_sm;
        o_push = 1'b0;
        o_echo = 1'b0;
        o_over = 1'b0;
        if (i_s1.valid && i_s1.rx) begin
            n_sm = cur;
            if (i_s1.last) begin
                o_push = 1'b1;
                o_over = i_s1.over;
                o_echo = !i_s1.over && (|(cur & i_slot_valid));
                n_sm   = '1;
            end
        end
        n_sm = n_sm & ~i_tx_clr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sm <= '1;
        end else begin
            r_sm <= n_sm;
        end
    end

endmodule

// ===== rtl/rtef_outq.sv =====
// Result queue between the compare stage and the output beat.
// Depends on rtef_pkg.
`timescale 1ns / 1ps

module rtef_outq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic [1:0]                    i_data,
    input  logic                          i_ready,
    output logic                          o_valid,
    output logic [1:0]                    o_data,
    output logic [rtef_pkg::OQ_CNT_W-1:0] o_cnt
);
    import rtef_pkg::*;

    logic [1:0]          r_q [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] r_wr;
    logic [OQ_PTR_W-1:0] r_rd;
    logic [OQ_CNT_W-1:0] r_cnt;
    logic                pop;

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_q[r_rd];
    assign o_cnt   = r_cnt;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/recent_transmit_echo_filter.sv =====
// Top level of the recent-transmit echo filter: position and slot control,
// frame store, compare stage and result queue. Depends on rtef_pkg and all rtef_* modules.
//
// channel  dir  tdata              tuser    tlast
// s        in   [7:0] frame_byte   opcode   last_byte
// m        out  [0] echo_match,    -        -
//               [1] oversize
//
// One byte per cycle while o_s_tready is high. A transmit byte writes its slot's bank
// at accept, a receive byte reads every bank at accept; the read data is compared in
// the following cycle, and the compare of a received frame's final byte queues its result.
// Reset is synchronous; no clearing pass is needed, lengths and valid bits are flops.
// o_s_tready drops only when the result queue could overflow.
`timescale 1ns / 1ps

module recent_transmit_echo_filter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] frame_byte
    input  logic       i_s_tuser,   // [0] opcode
    input  logic       i_s_tlast,
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata    // [0] echo_match, [1] oversize, [7:2] zero
);
    import rtef_pkg::*;

    logic [LEN_W-1:0]  r_tx_pos;
    logic [LEN_W-1:0]  n_tx_pos;
    logic [POS_W-1:0]  r_rx_pos;
    logic [POS_W-1:0]  n_rx_pos;
    logic [POS_W-1:0]  rx_pos_inc;
    logic [SLOT_W-1:0] r_wslot;
    logic [SLOT_W-1:0] n_wslot;
    t_mask             r_valid;
    t_mask             n_valid;
    logic [LEN_W-1:0]  r_len [RING_ENTRIES];
    logic [LEN_W-1:0]  tx_pos_inc;
    t_s1_ctl           r_s1;
    t_s1_ctl           n_s1;
    t_mask             tx_clr;
    t_mask             inlen;

    logic                accept;
    logic                is_rx;
    logic                tx_store;
    logic                tx_start;
    logic                s1_res;
    logic                push;
    logic                echo;
    logic                over;
    logic [1:0]          q_data;
    logic [OQ_CNT_W-1:0] q_cnt;
    t_bank_data          rd_data;

    assign accept   = i_s_tvalid && o_s_tready;
    assign is_rx    = (i_s_tuser == OP_RECEIVE);
    assign tx_start = accept && !is_rx && (r_tx_pos == '0);
    assign tx_store = accept && !is_rx && (r_tx_pos < LEN_W'(MAX_FRAME));
    assign tx_pos_inc = tx_store ? (r_tx_pos + 1'b1) : r_tx_pos;
    assign tx_clr   = tx_start ? (t_mask'(1) << r_wslot) : '0;
    assign rx_pos_inc = (r_rx_pos <= POS_W'(MAX_FRAME)) ? (r_rx_pos + 1'b1) : r_rx_pos;

    assign s1_res     = r_s1.valid && r_s1.rx && r_s1.last;
    assign o_s_tready = ((q_cnt + OQ_CNT_W'(s1_res)) <= OQ_CNT_W'(OQ_DEPTH - 1));

    always_comb begin
        for (int s = 0; s < RING_ENTRIES; s++) begin
            inlen[s] = ({1'b0, r_rx_pos} < {1'b0, r_len[s]});
        end
    end

    always_comb begin
        n_tx_pos = r_tx_pos;
        n_rx_pos = r_rx_pos;
        n_wslot  = r_wslot;
        n_valid  = r_valid;
        if (accept && !is_rx) begin
            n_tx_pos = tx_pos_inc;
            if (tx_start) begin
                n_valid[r_wslot] = 1'b0;
            end
            if (i_s_tlast) begin
                n_valid[r_wslot] = 1'b1;
                n_tx_pos = '0;
                n_wslot  = (r_wslot == SLOT_W'(RING_ENTRIES - 1)) ? '0 : (r_wslot + 1'b1);
            end
        end
        if (accept && is_rx) begin
            n_rx_pos = i_s_tlast ? '0 : rx_pos_inc;
        end
    end

    always_comb begin
        n_s1        = r_s1;
        n_s1.valid  = accept;
        n_s1.rx     = is_rx;
        n_s1.first  = (r_rx_pos == '0);
        n_s1.last   = i_s_tlast;
        n_s1.cmp_en = (r_rx_pos < POS_W'(MAX_FRAME));
        n_s1.over   = (rx_pos_inc > POS_W'(MAX_FRAME));
        n_s1.inlen  = inlen;
        n_s1.data   = i_s_tdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_pos <= '0;
            r_rx_pos <= '0;
            r_wslot  <= '0;
            r_valid  <= '0;
            r_s1     <= '0;
            for (int s = 0; s < RING_ENTRIES; s++) begin
                r_len[s] <= '0;
            end
        end else begin
            r_tx_pos <= n_tx_pos;
            r_rx_pos <= n_rx_pos;
            r_wslot  <= n_wslot;
            r_valid  <= n_valid;
            r_s1     <= n_s1;
            if (accept && !is_rx && i_s_tlast) begin
                r_len[r_wslot] <= tx_pos_inc;
            end
        end
    end

    rtef_store u_store (
        .i_clk     (i_clk),
        .i_we      (tx_store),
        .i_wslot   (r_wslot),
        .i_waddr   (r_tx_pos[ADDR_W-1:0]),
        .i_wdata   (i_s_tdata),
        .i_re      (accept && is_rx),
        .i_raddr   (r_rx_pos[ADDR_W-1:0]),
        .o_rd_data (rd_data)
    );

    rtef_match u_match (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s1         (r_s1),
        .i_rd_data    (rd_data),
        .i_slot_valid (r_valid),
        .i_tx_clr     (tx_clr),
        .o_push       (push),
        .o_echo       (echo),
        .o_over       (over)
    );

    rtef_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({over, echo}),
        .i_ready (i_m_tready),
        .o_valid (o_m_tvalid),
        .o_data  (q_data),
        .o_cnt   (q_cnt)
    );

    assign o_m_tdata = {6'b0, q_data};

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for recent_transmit_echo_filter: streams transmit and
// receive frames, predicts each echo verdict and compares it beat by beat.
// Depends on rtef_pkg and the recent_transmit_echo_filter RTL.
`timescale 1ns / 1ps

module tb_top;
    import rtef_pkg::*;

    localparam int CLK_PERIOD  = 12;
    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE      = 20;

    typedef logic [7:0] t_frame[$];

    typedef struct packed {
        logic echo_match;
        logic oversize;
    } t_verdict;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_s_tvalid;
    logic       o_s_tready;
    logic [7:0] i_s_tdata;   // [7:0] frame_byte
    logic       i_s_tuser;   // [0] opcode
    logic       i_s_tlast;
    logic       o_m_tvalid;
    logic       i_m_tready;
    logic [7:0] o_m_tdata;   // [0] echo_match, [1] oversize, [7:2] zero

    // predicted state of the ring
    logic [7:0] stored_bytes [RING_ENTRIES][MAX_FRAME];
    int         stored_len   [RING_ENTRIES];
    t_mask      filled;
    t_mask      candidates;
    int         fill_slot;
    int         tx_pos;
    int         rx_pos;

    t_verdict expected_verdicts[$];
    int errors         = 0;
    int cycles         = 0;
    int beats_sent     = 0;
    int verdicts_due   = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    recent_transmit_echo_filter dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        errors++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // advances the predicted state by one accepted beat
    function automatic void apply_frame_byte(input logic op, input logic [7:0] data,
                                             input logic last);
        t_verdict v;
        if (op == OP_TRANSMIT) begin
            if (tx_pos == 0) begin
                filled[fill_slot]     = 1'b0;
                candidates[fill_slot] = 1'b0;
            end
            if (tx_pos < MAX_FRAME) begin
                stored_bytes[fill_slot][tx_pos] = data;
                tx_pos++;
            end
            if (last) begin
                stored_len[fill_slot] = tx_pos;
                filled[fill_slot]     = 1'b1;
                fill_slot             = (fill_slot + 1) % RING_ENTRIES;
                tx_pos                = 0;
            end
        end else begin
            if (rx_pos == 0)
                candidates = filled;
            if (rx_pos < MAX_FRAME) begin
                for (int s = 0; s < RING_ENTRIES; s++) begin
                    if (candidates[s] && rx_pos < stored_len[s]
                        && stored_bytes[s][rx_pos] != data)
                        candidates[s] = 1'b0;
                end
            end
            if (rx_pos <= MAX_FRAME)
                rx_pos++;
            if (last) begin
                v.oversize   = (rx_pos > MAX_FRAME);
                v.echo_match = !v.oversize && ((candidates & filled) != '0);
                expected_verdicts.push_back(v);
                verdicts_due++;
                rx_pos     = 0;
                candidates = '1;
            end
        end
    endfunction

    // result checker
    always @(posedge i_clk) begin : check_results
        t_verdict want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_verdicts.size() == 0) begin
                report_mismatch($sformatf("result with none expected, tdata=%h", o_m_tdata));
            end else begin
                want = expected_verdicts.pop_front();
                if (o_m_tdata[0] !== want.echo_match)
                    report_mismatch($sformatf("echo_match got %b want %b",
                                              o_m_tdata[0], want.echo_match));
                if (o_m_tdata[1] !== want.oversize)
                    report_mismatch($sformatf("oversize got %b want %b",
                                              o_m_tdata[1], want.oversize));
                if (o_m_tdata[7:2] !== 6'd0)
                    report_mismatch($sformatf("pad bits got %b", o_m_tdata[7:2]));
            end
        end
    end

    // downstream ready
    initial begin
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // entered and left at a falling edge
    task automatic send_beat(input logic op, input logic [7:0] data, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= data;
        i_s_tuser  <= op;
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        apply_frame_byte(op, data, last);
        beats_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_frame(input logic op, input t_frame f);
        for (int i = 0; i < f.size(); i++)
            send_beat(op, f[i], i == f.size() - 1);
    endtask

    function automatic t_frame random_frame(input int len);
        t_frame f;
        repeat (len) f.push_back(8'($urandom));
        return f;
    endfunction

    function automatic int random_length();
        if ($urandom_range(9) == 0)
            return $urandom_range(13, 80);
        return $urandom_range(1, 12);
    endfunction

    function automatic t_frame slot_copy(input int s, input int len);
        t_frame f;
        for (int i = 0; i < len; i++)
            f.push_back(stored_bytes[s][i]);
        return f;
    endfunction

    function automatic int pick_filled_slot();
        int s;
        if (filled == '0)
            return -1;
        do s = $urandom_range(RING_ENTRIES - 1); while (!filled[s]);
        return s;
    endfunction

    // exact copy, prefix, extended copy or copy with one corrupted byte
    function automatic t_frame echo_variant(input int s);
        t_frame f;
        int     len;
        int     keep;
        int     idx;
        len = stored_len[s];
        if (len > 64)
            len = $urandom_range(1, 40);
        f = slot_copy(s, len);
        case ($urandom_range(3))
            0: ;
            1: begin
                keep = $urandom_range(1, len);
                while (f.size() > keep)
                    void'(f.pop_back());
            end
            2: repeat ($urandom_range(1, 6)) f.push_back(8'($urandom));
            default: begin
                idx    = $urandom_range(len - 1);
                f[idx] = f[idx] ^ 8'($urandom_range(1, 255));
            end
        endcase
        return f;
    endfunction

    task automatic send_interleaved(input t_frame tx, input t_frame rx);
        int ti;
        int ri;
        ti = 0;
        ri = 0;
        while (ti < tx.size() || ri < rx.size()) begin
            if (ri >= rx.size() || (ti < tx.size() && $urandom_range(1) == 0)) begin
                send_beat(OP_TRANSMIT, tx[ti], ti == tx.size() - 1);
                ti++;
            end else begin
                send_beat(OP_RECEIVE, rx[ri], ri == rx.size() - 1);
                ri++;
            end
        end
    endtask

    task automatic test_empty_ring();
        send_frame(OP_RECEIVE, '{8'h00, 8'hFF});
    endtask

    task automatic test_prefix_rules();
        send_frame(OP_TRANSMIT, '{8'h00, 8'hFF, 8'h5A});
        send_frame(OP_RECEIVE,  '{8'h00, 8'hFF, 8'h5A});
        send_frame(OP_RECEIVE,  '{8'h00});
        send_frame(OP_RECEIVE,  '{8'h00, 8'hFF, 8'h5A, 8'h11});
        send_frame(OP_RECEIVE,  '{8'h00, 8'hFE});
    endtask

    // a slot completed after a receive frame began must not match it
    task automatic test_slot_filled_mid_receive();
        send_beat(OP_RECEIVE, 8'hA5, 1'b0);
        send_frame(OP_TRANSMIT, '{8'hA5, 8'h3C});
        send_beat(OP_RECEIVE, 8'h3C, 1'b1);
        send_frame(OP_RECEIVE, '{8'hA5, 8'h3C});
    endtask

    // truncated transmit, receive at the limit, one past it, and well past it
    task automatic test_max_length();
        int     s;
        t_frame f;
        s = fill_slot;
        send_frame(OP_TRANSMIT, random_frame(MAX_FRAME + 3));
        f = slot_copy(s, MAX_FRAME);
        send_frame(OP_RECEIVE, f);
        f.push_back(8'($urandom));
        send_frame(OP_RECEIVE, f);
        repeat (11) f.push_back(8'($urandom));
        send_frame(OP_RECEIVE, f);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int beat_budget);
        int     beats_at_start;
        int     verdicts_at_start;
        int     pick;
        int     s;
        t_frame f;
        t_frame g;
        send_idle_pct     = idle_pct;
        recv_stall_pct    = stall_pct;
        beats_at_start    = beats_sent;
        verdicts_at_start = verdicts_due;
        while (beats_sent - beats_at_start < beat_budget
               || verdicts_due - verdicts_at_start < 15) begin
            pick = $urandom_range(99);
            s    = pick_filled_slot();
            if (s >= 0)
                f = echo_variant(s);
            else
                f = random_frame(random_length());
            if (pick < 30) begin
                send_frame(OP_TRANSMIT, random_frame(random_length()));
            end else if (pick < 68) begin
                send_frame(OP_RECEIVE, f);
            end else if (pick < 78) begin
                send_frame(OP_RECEIVE, random_frame(random_length()));
            end else if (pick < 86) begin
                // near duplicate, so several slots can hold the same prefix
                send_frame(OP_TRANSMIT, f);
            end else if (pick < 94) begin
                send_interleaved(random_frame(random_length()), f);
            end else if (filled[fill_slot]) begin
                // receive a copy of the slot whose overwrite is in progress
                s = fill_slot;
                g = slot_copy(s, (stored_len[s] > 64) ? 40 : stored_len[s]);
                send_beat(OP_TRANSMIT, 8'($urandom), 1'b0);
                send_frame(OP_RECEIVE, g);
                send_frame(OP_TRANSMIT, random_frame(random_length()));
            end else begin
                send_frame(OP_TRANSMIT, random_frame(random_length()));
            end
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = 8'h00;
        i_s_tuser  = OP_TRANSMIT;
        i_s_tlast  = 1'b0;
        for (int s = 0; s < RING_ENTRIES; s++)
            stored_len[s] = 0;
        filled     = '0;
        candidates = '1;
        fill_slot  = 0;
        tx_pos     = 0;
        rx_pos     = 0;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_empty_ring();
        test_prefix_rules();
        test_slot_filled_mid_receive();
        test_max_length();
        test_random_traffic(0, 0, 175);
        test_random_traffic(78, 0, 175);
        test_random_traffic(0, 78, 175);
        test_random_traffic(38, 38, 175);

        i_s_tvalid <= 1'b0;
        while (expected_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
